// ----- hw/rtl/assert_macros.svh -----
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error("assert failed");
`define ASSERT_NEVER(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(prop)) else $error("never failed");
`else
`define ASSERT_IMPL(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, prop)
`endif
`endif

// ----- hw/rtl/iff_pkg.sv -----
package iff_pkg;
  localparam logic [2:0] KIND_UDEC = 3'd0;
  localparam logic [2:0] KIND_SDEC = 3'd1;
  localparam logic [2:0] KIND_BIN  = 3'd2;
  localparam logic [2:0] KIND_OCT  = 3'd3;
  localparam logic [2:0] KIND_HEX  = 3'd4;

  localparam logic [1:0] RADIX_DEC = 2'd0;
  localparam logic [1:0] RADIX_BIN = 2'd1;
  localparam logic [1:0] RADIX_OCT = 2'd2;
  localparam logic [1:0] RADIX_HEX = 2'd3;

  // characters packed into one output beat
  localparam int CHARS_PER_RESULT = 4;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;

  // digit conversion control
  typedef struct packed {
    logic       start;
    logic [1:0] radix_sel; // 0 dec, 1 bin, 2 oct, 3 hex
  } conv_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } conv_sts_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic up);
    logic [7:0] r;
    if (d > 4'd9) r = {4'd0, d} + (up ? 8'd55 : 8'd87);
    else r = {4'd0, d} + CH_ZERO;
    return r;
  endfunction
endpackage

// ----- hw/rtl/integer_field_formatter.sv -----
// integer_field_formatter: turns one 64-bit value plus printf-style options
// into its ascii text, sent as beats of up to CHARS_PER_RESULT characters with
// the first character in the low byte and tlast on the final beat. an item
// is taken while idle; decimal then runs shift-and-add-3 in the shared digit
// unit, and every kind drops leading zero digits one per cycle (from 20
// digits for decimal, 64 binary, 22 octal, 16 hex), then the unit closes,
// hands off its digits and the layout is planned. each beat then packs one
// character per cycle and waits on the output while tready is low.
// the block accepts no new item until the last beat of the current one has
// been taken.
module integer_field_formatter #(
  parameter int MAX_FIELD = 120
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // value[63:0], kind[66:64], upper_case[67], left_align[68], zero_pad[69],
  // sign_mode[71:70], alt_form[72], hide_prefix[73], field_width[80:74],
  // precision_given[81], min_digits[88:82], zeros to 95
  input  logic [95:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // chars[31:0], char_count[34:32], zeros to 39
  output logic [39:0] m_axis_tdata,
  output logic        m_axis_tlast
);
  `include "assert_macros.svh"

  localparam int CPR    = iff_pkg::CHARS_PER_RESULT;
  localparam int MAXRES = 31;
  localparam int CW     = $clog2(CPR + 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CONV = 3'd1;
  localparam logic [2:0] ST_PLAN = 3'd2;
  localparam logic [2:0] ST_EMIT = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  logic [2:0] st_q, st_d;
  logic [63:0] mag;
  logic neg;
  logic [2:0] kind;
  logic [1:0] rsel;
  logic left_q, zpad_q, nopre_q, pg_q;
  logic [7:0] width_q, prec_q;
  logic [7:0] pre0_q, pre1_q;
  logic [1:0] plen_q;
  logic [6:0] nd;
  logic dig_pop;
  logic [7:0] dig_char;
  iff_pkg::conv_ctl_t ctl;
  iff_pkg::conv_sts_t sts;

  // layout counts
  logic [7:0] lead_q, zeros_q, trail_q;
  logic [8:0] pos_q;
  logic [8:0] total_q;
  logic [7:0] cur;
  logic [31:0] word_q;
  logic [CW-1:0] cnt_q;
  logic [8:0] emitted_q;
  logic [5:0] nres_q;

  function automatic logic [7:0] sat(input logic [6:0] x);
    return (int'(x) > MAX_FIELD) ? 8'(MAX_FIELD) : {1'b0, x};
  endfunction

  assign kind = s_axis_tdata[66:64];
  assign neg  = (kind == iff_pkg::KIND_SDEC) && s_axis_tdata[63];
  assign mag  = neg ? (~s_axis_tdata[63:0] + 64'd1) : s_axis_tdata[63:0];
  always_comb begin
    case (kind)
      iff_pkg::KIND_BIN: rsel = iff_pkg::RADIX_BIN;
      iff_pkg::KIND_OCT: rsel = iff_pkg::RADIX_OCT;
      iff_pkg::KIND_HEX: rsel = iff_pkg::RADIX_HEX;
      default:           rsel = iff_pkg::RADIX_DEC;
    endcase
  end

  assign s_axis_tready = (st_q == ST_IDLE);
  assign ctl = '{start: s_axis_tvalid && s_axis_tready, radix_sel: rsel};

  iff_conv u_conv (
    .clk_i, .rst_ni, .ctl_i(ctl), .value_i(mag), .up_i(s_axis_tdata[67]),
    .pop_i(dig_pop), .sts_o(sts), .nd_o(nd), .dig_char_o(dig_char)
  );

  // plan arithmetic, signed 11 bits
  logic signed [10:0] w_s, z_s;
  always_comb begin
    w_s = $signed({3'd0, width_q}) - $signed({9'd0, plen_q}) - $signed({4'd0, nd});
    z_s = $signed({3'd0, prec_q}) - $signed({4'd0, nd});
  end

  // character at pos in text
  logic [8:0] p_lead, p_pre, p_zero, p_dig;
  assign p_lead = {1'b0, lead_q};
  assign p_pre  = p_lead + (nopre_q ? 9'd0 : {7'd0, plen_q});
  assign p_zero = p_pre + {1'b0, zeros_q};
  assign p_dig  = p_zero + {2'd0, nd};
  // digits leave the unit most significant first
  assign dig_pop = (st_q == ST_EMIT) && (pos_q >= p_zero) && (pos_q < p_dig);
  always_comb begin
    if (pos_q < p_lead) cur = iff_pkg::CH_SPACE;
    else if (pos_q < p_pre) cur = (pos_q == p_lead) ? pre0_q : pre1_q;
    else if (pos_q < p_zero) cur = iff_pkg::CH_ZERO;
    else if (pos_q < p_dig) cur = dig_char;
    else cur = iff_pkg::CH_SPACE;
  end

  logic beat_take;
  assign beat_take = m_axis_tvalid && m_axis_tready;
  logic out_last;
  assign out_last = (emitted_q >= total_q) || (nres_q == 6'(MAXRES - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_IDLE: if (ctl.start) st_d = ST_CONV;
      ST_CONV: if (sts.done) st_d = ST_PLAN;
      ST_PLAN: st_d = ST_EMIT;
      ST_EMIT: if (int'(cnt_q) == CPR - 1 || pos_q + 9'd1 >= total_q)
                 st_d = ST_OUT;
      ST_OUT: if (m_axis_tready) st_d = out_last ? ST_IDLE : ST_EMIT;
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      ST_IDLE: if (ctl.start) begin
        left_q <= s_axis_tdata[68];
        zpad_q <= s_axis_tdata[69] && !s_axis_tdata[68];
        nopre_q <= s_axis_tdata[73]; pg_q <= s_axis_tdata[81];
        width_q <= sat(s_axis_tdata[80:74]); prec_q <= sat(s_axis_tdata[88:82]);
        pre1_q <= 8'd0;
        if (neg) begin pre0_q <= iff_pkg::CH_MINUS; plen_q <= 2'd1; end
        else if (s_axis_tdata[71:70] == 2'd1) begin
          pre0_q <= iff_pkg::CH_SPACE; plen_q <= 2'd1;
        end else if (s_axis_tdata[71:70] >= 2'd2) begin
          pre0_q <= iff_pkg::CH_PLUS; plen_q <= 2'd1;
        end else if (s_axis_tdata[72] && rsel != iff_pkg::RADIX_DEC) begin
          pre0_q <= iff_pkg::CH_ZERO;
          if (rsel == iff_pkg::RADIX_BIN) begin
            pre1_q <= s_axis_tdata[67] ? 8'h42 : 8'h62; plen_q <= 2'd2;
          end else if (rsel == iff_pkg::RADIX_HEX) begin
            pre1_q <= s_axis_tdata[67] ? 8'h58 : 8'h78; plen_q <= 2'd2;
          end else plen_q <= 2'd1;
        end else begin
          pre0_q <= 8'd0; plen_q <= 2'd0;
        end
      end
      ST_PLAN: begin
        logic signed [10:0] w, z;
        w = w_s; z = 11'sd0;
        if (pg_q) begin
          if (z_s > 0) begin z = z_s; w = w - z_s; end
        end else if (zpad_q && w > 0) begin
          z = w; w = 11'sd0;
        end
        zeros_q <= 8'(z);
        lead_q  <= (w > 0 && !left_q) ? 8'(w) : 8'd0;
        trail_q <= (w > 0 && left_q) ? 8'(w) : 8'd0;
        total_q <= 9'(w > 0 ? w : 11'sd0) + 9'(z) + {2'd0, nd}
                   + (nopre_q ? 9'd0 : {7'd0, plen_q});
        pos_q <= 9'd0; cnt_q <= '0; word_q <= 32'd0;
        emitted_q <= 9'd0; nres_q <= 6'd0;
      end
      ST_EMIT: begin
        word_q <= word_q | ({24'd0, cur} << (8 * int'(cnt_q)));
        cnt_q <= cnt_q + CW'(1);
        pos_q <= pos_q + 9'd1;
        emitted_q <= emitted_q + 9'd1;
      end
      ST_OUT: if (m_axis_tready) begin
        word_q <= 32'd0; cnt_q <= '0; nres_q <= nres_q + 6'd1;
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid = (st_q == ST_OUT);
  assign m_axis_tdata  = {5'd0, 3'(cnt_q), word_q};
  assign m_axis_tlast  = out_last;

  `ASSERT_IMPL(a_busy_no_ready, clk_i, rst_ni, sts.busy |-> !s_axis_tready)
  `ASSERT_IMPL(a_beat_count, clk_i, rst_ni, m_axis_tvalid |-> cnt_q != '0)
  `ASSERT_IMPL(a_out_to_idle, clk_i, rst_ni, (beat_take && m_axis_tlast) |=> st_q == ST_IDLE)
  `ASSERT_NEVER(a_conv_idle, clk_i, rst_ni, sts.done && st_q != ST_CONV)
endmodule

// ----- hw/rtl/iff_conv.sv -----
// shared digit unit: shift-and-add-3 binary to bcd for decimal, one input bit
// per cycle, then leading zero digits are dropped one per cycle so that the
// most significant digit sits in the top nibble, where it is read and popped
module iff_conv (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  iff_pkg::conv_ctl_t ctl_i,
  input  logic [63:0]        value_i,
  input  logic               up_i,
  input  logic               pop_i,
  output iff_pkg::conv_sts_t sts_o,
  output logic [6:0]         nd_o,
  output logic [7:0]         dig_char_o
);
  `include "assert_macros.svh"

  logic [255:0] dig_q, dig_d;
  logic [63:0]  val_q, val_d;
  logic [5:0]   step_q, step_d;
  logic [6:0]   nd_q, nd_d;
  logic         trim_q, trim_d;
  logic         busy_q, busy_d, done_q, done_d, up_q, up_d;
  logic [79:0]  bcd_adj;
  logic [65:0]  oct_v;

  always_comb begin
    dig_d = dig_q; val_d = val_q; step_d = step_q; nd_d = nd_q; trim_d = trim_q;
    busy_d = busy_q; done_d = 1'b0; up_d = up_q;
    oct_v = {2'd0, value_i};
    // add 3 to every bcd digit of 5 or more before the shift
    for (int i = 0; i < 20; i++) begin
      bcd_adj[4*i +: 4] = (dig_q[176 + 4*i +: 4] >= 4'd5) ?
                          (dig_q[176 + 4*i +: 4] + 4'd3) : dig_q[176 + 4*i +: 4];
    end
    if (ctl_i.start) begin
      busy_d = 1'b1; up_d = up_i; val_d = value_i; step_d = 6'd63;
      dig_d = '0;
      case (ctl_i.radix_sel)
        iff_pkg::RADIX_BIN: begin
          for (int i = 0; i < 64; i++) dig_d[4*i +: 4] = {3'd0, value_i[i]};
          nd_d = 7'd64; trim_d = 1'b1;
        end
        iff_pkg::RADIX_OCT: begin
          for (int i = 0; i < 22; i++) dig_d[168 + 4*i +: 4] = {1'b0, oct_v[3*i +: 3]};
          nd_d = 7'd22; trim_d = 1'b1;
        end
        iff_pkg::RADIX_HEX: begin
          dig_d[255:192] = value_i; nd_d = 7'd16; trim_d = 1'b1;
        end
        default: begin
          nd_d = 7'd20; trim_d = 1'b0;
        end
      endcase
    end else if (busy_q) begin
      if (!trim_q) begin
        dig_d[255:176] = {bcd_adj[78:0], val_q[63]};
        val_d = {val_q[62:0], 1'b0};
        step_d = step_q - 6'd1;
        if (step_q == 6'd0) trim_d = 1'b1;
      end else if (dig_q[255:252] == 4'd0 && nd_q != 7'd1) begin
        dig_d = {dig_q[251:0], 4'd0};
        nd_d = nd_q - 7'd1;
      end else begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end else if (pop_i) begin
      dig_d = {dig_q[251:0], 4'd0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; nd_q <= 7'd0; step_q <= 6'd0;
      trim_q <= 1'b0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; nd_q <= nd_d; step_q <= step_d;
      trim_q <= trim_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dig_q <= dig_d; val_q <= val_d; up_q <= up_d;
  end

  // most significant remaining digit
  assign dig_char_o = iff_pkg::digit_char(dig_q[255:252], up_q);
  assign nd_o  = nd_q;
  assign sts_o = '{busy: busy_q, done: done_q};

  `ASSERT_IMPL(a_done_pulse, clk_i, rst_ni, done_q |=> !done_q)
  `ASSERT_NEVER(a_busy_done, clk_i, rst_ni, busy_q && done_q)
  `ASSERT_NEVER(a_bcd_fits, clk_i, rst_ni, busy_q && !trim_q && bcd_adj[79])
  `ASSERT_IMPL(a_done_digits, clk_i, rst_ni, done_q |-> (dig_q[255:252] != 4'd0 || nd_q == 7'd1))
endmodule
